[hw/rtl/wpsd_pkg.sv]
// shared constants and types of the windowed peak/valley step detector
// used by wpsd_scan and windowed_peak_step_detector_core
`default_nettype none

package wpsd_pkg;

	localparam int HALF_WINDOW = 12;
	localparam int WIN_LEN     = 2 * HALF_WINDOW;
	localparam int ADDR_W      = $clog2(WIN_LEN);
	localparam int CNT_W       = $clog2(WIN_LEN + 1);
	localparam int IDX_W       = $clog2(HALF_WINDOW);
	localparam int SMP_W       = 16;
	localparam int SENS_W      = 12;
	localparam int THR_W       = 17;
	localparam int CMP_W       = THR_W + 2;
	localparam int BATCH_W     = 8;
	localparam int SMOOTH_LAG  = 3;
	localparam logic [SENS_W-1:0] SENS_RESET = SENS_W'(150);

	typedef struct packed {
		logic              valid;
		logic              half;
		logic              last;
		logic [IDX_W-1:0]  idx;
		logic [ADDR_W-1:0] addr;
	} scan_ctl_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [SMP_W-1:0]  data;
	} wb_t;

endpackage

`default_nettype wire

[hw/rtl/wpsd_scan.sv]
// smoothing filter and peak/valley tracker over one window walk
// depends on wpsd_pkg; fed with registered memory read data by the top level
`default_nettype none

module wpsd_scan (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  wpsd_pkg::scan_ctl_t                     ctl_s1,
	input  logic signed [wpsd_pkg::SMP_W-1:0]       rd_data_s1,
	input  logic signed [wpsd_pkg::CMP_W-1:0]       up,
	input  logic signed [wpsd_pkg::CMP_W-1:0]       down,
	output logic signed [wpsd_pkg::SMP_W-1:0]       peak,
	output logic signed [wpsd_pkg::SMP_W-1:0]       valley,
	output logic                                    done,
	output wpsd_pkg::wb_t                           wb
);

	localparam int SUM_W = wpsd_pkg::SMP_W + 2;

	logic signed [wpsd_pkg::SMP_W-1:0] tap1_q, tap2_q, tap3_q;
	logic signed [SUM_W-1:0]           sum;
	logic signed [SUM_W-1:0]           sum_adj;
	logic signed [wpsd_pkg::SMP_W-1:0] smooth;
	logic signed [wpsd_pkg::SMP_W-1:0] sm_s2;
	wpsd_pkg::scan_ctl_t               ctl_s2;
	logic signed [wpsd_pkg::CMP_W-1:0] sm_ext;
	logic signed [wpsd_pkg::SMP_W-1:0] peak_q, valley_q;
	logic                              done_q;

	// four-tap average of original values, truncated toward zero; raw at idx < 3
	always_comb begin
		sum = SUM_W'(rd_data_s1) + SUM_W'(tap1_q) + SUM_W'(tap2_q) + SUM_W'(tap3_q);
		sum_adj = sum + (sum[SUM_W-1] ? SUM_W'(3) : SUM_W'(0));
		if (ctl_s1.idx < wpsd_pkg::IDX_W'(wpsd_pkg::SMOOTH_LAG)) begin
			smooth = rd_data_s1;
		end else begin
			smooth = sum_adj[SUM_W-1:2];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			tap1_q <= rd_data_s1;
			tap2_q <= tap1_q;
			tap3_q <= tap2_q;
		end
		sm_s2 <= smooth;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	assign sm_ext = wpsd_pkg::CMP_W'(sm_s2);

	// first half tracks the peak, second half the valley
	always_ff @(posedge clk) begin
		if (ctl_s2.valid && !ctl_s2.half) begin
			if (ctl_s2.idx == '0) begin
				peak_q <= sm_s2;
			end else if (sm_s2 > peak_q && sm_ext > up) begin
				peak_q <= sm_s2;
			end
		end
		if (ctl_s2.valid && ctl_s2.half) begin
			if (ctl_s2.idx == '0) begin
				valley_q <= sm_s2;
			end else if (sm_s2 < valley_q && sm_ext < down) begin
				valley_q <= sm_s2;
			end
		end
	end

	// smoothed second half goes back to the store
	always_comb begin
		wb.en   = ctl_s2.valid && ctl_s2.half;
		wb.addr = ctl_s2.addr;
		wb.data = sm_s2;
	end

	assign peak   = peak_q;
	assign valley = valley_q;
	assign done   = done_q;

endmodule

`default_nettype wire

[hw/rtl/windowed_peak_step_detector_core.sv]
// top level of the windowed peak/valley step detector: sample store and control
// depends on wpsd_pkg and wpsd_scan
//
// Input channel (in_valid/in_stall, sample, batch_end) takes one acceleration
// sample per transfer; every sample yields exactly one result on the output
// channel (out_valid/out_stall, window_done, step_found, batch_steps).
// Samples go into a 24-entry store. A sample that does not fill the window
// gives its result through the pending and output registers, and the next
// sample is taken once the pending register is free. The sample that fills
// the window starts a walk over the store, one read per cycle through its
// single read port; in_stall is held high until the pending register is free.
// The smoothed second half is written back in place and the two halves swap
// roles through a base pointer, so no copy is needed.
// One result may wait in a pending register while the output register is
// stalled; after that in_stall rises until the receiver takes a transfer.
// The user must write sensitivity (cfg_wr_en/cfg_wr_data) only while the block
// is idle, not enforced by the block. Reset clears the fill count, threshold,
// batch counter and handshake state (not the store); sensitivity goes to 150.
`default_nettype none

module windowed_peak_step_detector_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [wpsd_pkg::SENS_W-1:0]         cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [wpsd_pkg::SMP_W-1:0]   sample,
	input  logic                                batch_end,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                window_done,
	output logic                                step_found,
	output logic [wpsd_pkg::BATCH_W-1:0]        batch_steps
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	localparam int AW = wpsd_pkg::ADDR_W;
	localparam int CW = wpsd_pkg::CNT_W;

	logic [1:0]                        state_q;
	logic [CW-1:0]                     fill_q;
	logic                              base_q;
	logic [wpsd_pkg::THR_W-1:0]        thr_q;
	logic [wpsd_pkg::BATCH_W-1:0]      batch_q;
	logic [wpsd_pkg::SENS_W-1:0]       sens_q;
	logic                              bend_q;
	logic [AW-1:0]                     scan_k_q;

	logic signed [wpsd_pkg::SMP_W-1:0] win_mem [wpsd_pkg::WIN_LEN];
	logic signed [wpsd_pkg::SMP_W-1:0] rd_data_s1;
	logic [AW-1:0]                     rd_addr;
	logic                              mem_we;
	logic [AW-1:0]                     mem_wa;
	logic signed [wpsd_pkg::SMP_W-1:0] mem_wd;

	wpsd_pkg::scan_ctl_t               ctl_s1;
	wpsd_pkg::scan_ctl_t               ctl_next;
	wpsd_pkg::wb_t                     wb;

	logic signed [wpsd_pkg::CMP_W-1:0] up, down;
	logic signed [wpsd_pkg::SMP_W-1:0] peak, valley;
	logic                              scan_done;

	logic                              in_xfer;
	logic [CW-1:0]                     fill_next;
	logic                              win_full;
	logic signed [wpsd_pkg::THR_W-1:0] diff_s;
	logic [wpsd_pkg::THR_W-1:0]        diff;
	logic                              is_step;
	logic [wpsd_pkg::BATCH_W-1:0]      batch_inc;

	logic                              pend_set;
	logic                              pend_done, pend_step;
	logic [wpsd_pkg::BATCH_W-1:0]      pend_batch;
	logic                              pend_v_q;
	logic                              pend_done_q, pend_step_q;
	logic [wpsd_pkg::BATCH_W-1:0]      pend_batch_q;
	logic                              out_v_q;
	logic                              out_done_q, out_step_q;
	logic [wpsd_pkg::BATCH_W-1:0]      out_batch_q;
	logic                              out_load;

	function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] j, input logic base);
		logic [AW:0] sum;
		sum = {1'b0, j} + (base ? (AW+1)'(wpsd_pkg::HALF_WINDOW) : (AW+1)'(0));
		if (sum >= (AW+1)'(wpsd_pkg::WIN_LEN)) begin
			sum = sum - (AW+1)'(wpsd_pkg::WIN_LEN);
		end
		return sum[AW-1:0];
	endfunction

	assign in_stall  = (state_q != ST_IDLE) || pend_v_q;
	assign in_xfer   = in_valid && !in_stall;
	assign fill_next = fill_q + CW'(1);
	assign win_full  = fill_next == CW'(wpsd_pkg::WIN_LEN);

	assign up   = wpsd_pkg::CMP_W'(thr_q) + wpsd_pkg::CMP_W'(sens_q[wpsd_pkg::SENS_W-1:1]);
	assign down = wpsd_pkg::CMP_W'(thr_q) - wpsd_pkg::CMP_W'(sens_q[wpsd_pkg::SENS_W-1:1]);

	// store: one write port, one registered read port
	assign rd_addr = phys_addr(scan_k_q, base_q);

	always_comb begin
		if (wb.en) begin
			mem_we = 1'b1;
			mem_wa = wb.addr;
			mem_wd = wb.data;
		end else begin
			mem_we = in_xfer;
			mem_wa = phys_addr(fill_q[AW-1:0], base_q);
			mem_wd = sample;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			win_mem[mem_wa] <= mem_wd;
		end
		rd_data_s1 <= win_mem[rd_addr];
	end

	// walk control travelling with the read data
	always_comb begin
		ctl_next.valid = state_q == ST_SCAN;
		ctl_next.half  = scan_k_q >= AW'(wpsd_pkg::HALF_WINDOW);
		ctl_next.last  = scan_k_q == AW'(wpsd_pkg::WIN_LEN - 1);
		ctl_next.addr  = rd_addr;
		if (ctl_next.half) begin
			ctl_next.idx = wpsd_pkg::IDX_W'(scan_k_q - AW'(wpsd_pkg::HALF_WINDOW));
		end else begin
			ctl_next.idx = wpsd_pkg::IDX_W'(scan_k_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_next;
		end
	end

	wpsd_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s1     (ctl_s1),
		.rd_data_s1 (rd_data_s1),
		.up         (up),
		.down       (down),
		.peak       (peak),
		.valley     (valley),
		.done       (scan_done),
		.wb         (wb)
	);

	// window decision
	assign diff_s    = wpsd_pkg::THR_W'(peak) - wpsd_pkg::THR_W'(valley);
	assign diff      = diff_s;
	assign is_step   = !(peak < valley) && (diff > wpsd_pkg::THR_W'(sens_q));
	assign batch_inc = (batch_q == '1) ? batch_q : batch_q + wpsd_pkg::BATCH_W'(1);

	always_comb begin
		pend_set   = 1'b0;
		pend_done  = 1'b0;
		pend_step  = 1'b0;
		pend_batch = batch_q;
		if (in_xfer && !win_full) begin
			pend_set = 1'b1;
		end else if (state_q == ST_WAIT && scan_done) begin
			pend_set  = 1'b1;
			pend_done = 1'b1;
			pend_step = is_step;
			if (is_step) begin
				pend_batch = batch_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			base_q   <= 1'b0;
			thr_q    <= '0;
			batch_q  <= '0;
			sens_q   <= wpsd_pkg::SENS_RESET;
			bend_q   <= 1'b0;
			scan_k_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				sens_q <= cfg_wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						bend_q <= batch_end;
						if (win_full) begin
							state_q  <= ST_SCAN;
							scan_k_q <= '0;
						end else begin
							fill_q <= fill_next;
							if (batch_end) begin
								batch_q <= '0;
							end
						end
					end
				end
				ST_SCAN: begin
					if (scan_k_q == AW'(wpsd_pkg::WIN_LEN - 1)) begin
						state_q <= ST_WAIT;
					end else begin
						scan_k_q <= scan_k_q + AW'(1);
					end
				end
				ST_WAIT: begin
					if (scan_done) begin
						state_q <= ST_IDLE;
						if (is_step) begin
							thr_q   <= diff;
							fill_q  <= '0;
							batch_q <= bend_q ? '0 : batch_inc;
						end else begin
							base_q  <= !base_q;
							fill_q  <= CW'(wpsd_pkg::HALF_WINDOW);
							if (bend_q) begin
								batch_q <= '0;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// pending result and output register
	assign out_load = !out_v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (pend_set) begin
				pend_v_q <= 1'b1;
			end else if (out_load) begin
				pend_v_q <= 1'b0;
			end
			if (out_load) begin
				out_v_q <= pend_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_set) begin
			pend_done_q  <= pend_done;
			pend_step_q  <= pend_step;
			pend_batch_q <= pend_batch;
		end
		if (out_load) begin
			out_done_q  <= pend_done_q;
			out_step_q  <= pend_step_q;
			out_batch_q <= pend_batch_q;
		end
	end

	assign out_valid   = out_v_q;
	assign window_done = out_done_q;
	assign step_found  = out_step_q;
	assign batch_steps = out_batch_q;

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CW'(wpsd_pkg::WIN_LEN))
		else $error("fill count out of range");

	a_wb_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		wb.en |-> (state_q == ST_SCAN || state_q == ST_WAIT))
		else $error("store write-back outside a window walk");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> state_q == ST_WAIT)
		else $error("walk finished outside the wait state");

	a_pend_free: assert property (@(posedge clk) disable iff (!arst_n)
		pend_set |-> !pend_v_q)
		else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
